/* design/hpq_pkg.sv */
// Shared types and constants for the max-heap priority queue.
`timescale 1ns / 1ps

package hpq_pkg;

  // Default sizing, used as the parameter defaults of the top level and its submodules
  localparam int CAPACITY_DEF  = 1024;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed widths of the channel payloads
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // Action codes on the input channel
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_LOAD,
    S_DN_SEL,
    S_DN_CMP,
    S_DN_FIN,
    S_DONE
  } hpq_state_t;

endpackage

/* design/hpq_if.sv */
// Valid/ready channel interfaces for queue commands and results.
`timescale 1ns / 1ps

interface hpq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [hpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface hpq_out_if;
  logic                                valid;
  logic                                ready;
  logic [hpq_pkg::STATUS_W-1:0]        status;
  logic signed [hpq_pkg::VALUE_W-1:0]  removed_value;
  logic signed [hpq_pkg::VALUE_W-1:0]  top_value;
  logic [hpq_pkg::COUNT_W-1:0]         count;

  modport source (output valid, output status, output removed_value, output top_value,
                  output count, input ready);
  modport sink   (input valid, input status, input removed_value, input top_value,
                  input count, output ready);
endinterface

/* design/hpq_cmp.sv */
// Shared signed key comparator used by both sift directions.
`timescale 1ns / 1ps

module hpq_cmp #(
  parameter int KEY_WIDTH = hpq_pkg::KEY_WIDTH_DEF
) (
  input  logic [KEY_WIDTH-1:0] a,
  input  logic [KEY_WIDTH-1:0] b,
  output logic                 gt
);
  import hpq_pkg::*;

  // strict greater-than, two's complement
  assign gt = $signed(a) > $signed(b);

endmodule

/* design/hpq_mem.sv */
// Heap key storage: one write port, two registered read ports.
`timescale 1ns / 1ps

module hpq_mem #(
  parameter int  DEPTH = hpq_pkg::CAPACITY_DEF,
  parameter int  DW    = hpq_pkg::KEY_WIDTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);
  import hpq_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* design/hpq_ctrl.sv */
// Sequencer for insert / delete-max: sift up and sift down over the key store.
`timescale 1ns / 1ps

module hpq_ctrl #(
  parameter int  CAPACITY  = hpq_pkg::CAPACITY_DEF,
  parameter int  KEY_WIDTH = hpq_pkg::KEY_WIDTH_DEF,
  localparam int CW        = $clog2(CAPACITY + 1),
  localparam int AW        = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hpq_in_if.sink               in_ch,
  hpq_out_if.source            out_ch,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [KEY_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]        mem_raddr_a,
  output logic [AW-1:0]        mem_raddr_b,
  input  logic [KEY_WIDTH-1:0] mem_rdata_a,
  input  logic [KEY_WIDTH-1:0] mem_rdata_b,
  output logic [KEY_WIDTH-1:0] cmp_a,
  output logic [KEY_WIDTH-1:0] cmp_b,
  input  logic                 cmp_gt
);
  import hpq_pkg::*;

  hpq_state_t state_r, state_nxt;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] child_val_r, child_val_nxt;
  logic [CW-1:0]        child_idx_r, child_idx_nxt;
  logic [KEY_WIDTH-1:0] root_r, root_nxt;
  logic [KEY_WIDTH-1:0] removed_r, removed_nxt;
  status_t              status_r, status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]   out_removed_r, out_removed_nxt;
  logic [VALUE_W-1:0]   out_top_r, out_top_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic                 in_fire;
  logic                 heap_full;
  logic                 heap_empty;
  logic                 out_load;
  logic [CW-1:0]        probe;
  logic [CW:0]          lslot;
  logic [CW:0]          sel_l;
  logic                 take_right;
  logic [CW-1:0]        wslot;
  logic [CW:0]          rd_slot_a;
  logic [CW:0]          rd_slot_b;
  logic [VALUE_W+KEY_WIDTH-1:0] in_ext;
  logic [VALUE_W+KEY_WIDTH-1:0] top_ext;
  logic [VALUE_W+KEY_WIDTH-1:0] rem_ext;
  logic [COUNT_W+CW-1:0]        cnt_ext;

  // handshake and simple flags
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign heap_full   = (cnt_r == CW'(CAPACITY));
  assign heap_empty  = (cnt_r == '0);
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // key taken from the 32-bit value: truncated or sign-extended to KEY_WIDTH
  assign in_ext = {{KEY_WIDTH{in_ch.value[VALUE_W-1]}}, in_ch.value};

  // left child slot of the node being probed on the way down
  assign probe = (state_r == S_DN_LOAD) ? CW'(1) : child_idx_r;
  assign lslot = {probe, 1'b0};

  // child choice: right only when it exists and is strictly greater
  assign sel_l      = {pos_r, 1'b0};
  assign take_right = (sel_l < {1'b0, cnt_r}) && cmp_gt;

  // slot numbers are 1-based, memory addresses 0-based
  assign mem_waddr   = AW'(wslot - CW'(1));
  assign mem_raddr_a = AW'(rd_slot_a - (CW + 1)'(1));
  assign mem_raddr_b = AW'(rd_slot_b - (CW + 1)'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.action == ACT_INSERT) begin
            state_nxt = heap_full ? S_DONE : S_UP_RD;
          end else begin
            state_nxt = heap_empty ? S_DONE : S_DN_LAST;
          end
        end
      end
      S_UP_RD:   state_nxt = (pos_r == CW'(1)) ? S_DONE : S_UP_CMP;
      S_UP_CMP:  state_nxt = cmp_gt ? S_UP_RD : S_DONE;
      S_DN_LAST: state_nxt = S_DN_LOAD;
      S_DN_LOAD: begin
        if (heap_empty) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = (lslot > {1'b0, cnt_r}) ? S_DN_FIN : S_DN_SEL;
        end
      end
      S_DN_SEL:  state_nxt = S_DN_CMP;
      S_DN_CMP: begin
        if (cmp_gt) begin
          state_nxt = (lslot > {1'b0, cnt_r}) ? S_DN_FIN : S_DN_SEL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_FIN:  state_nxt = S_DONE;
      S_DONE:    state_nxt = out_load ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory port and comparator operand control
  always_comb begin
    mem_we    = 1'b0;
    wslot     = pos_r;
    mem_wdata = key_r;
    rd_slot_a = lslot;
    rd_slot_b = lslot + (CW + 1)'(1);
    cmp_a     = key_r;
    cmp_b     = mem_rdata_a;
    case (state_r)
      S_UP_RD: begin
        rd_slot_a = {1'b0, pos_r >> 1};
        mem_we    = (pos_r == CW'(1));
      end
      S_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = cmp_gt ? mem_rdata_a : key_r;
      end
      S_DN_LAST: begin
        rd_slot_a = {1'b0, cnt_r} + (CW + 1)'(1);
      end
      S_DN_SEL: begin
        cmp_a = mem_rdata_b;
        cmp_b = mem_rdata_a;
      end
      S_DN_CMP: begin
        cmp_a     = child_val_r;
        cmp_b     = key_r;
        mem_we    = 1'b1;
        mem_wdata = cmp_gt ? child_val_r : key_r;
      end
      S_DN_FIN: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // datapath register updates
  always_comb begin
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    child_val_nxt = child_val_r;
    child_idx_nxt = child_idx_r;
    root_nxt      = root_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;

    // root copy follows every write to slot one
    if (mem_we && (wslot == CW'(1))) begin
      root_nxt = mem_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          removed_nxt = '0;
          status_nxt  = ST_OK;
          if (in_ch.action == ACT_INSERT) begin
            if (heap_full) begin
              status_nxt = ST_FULL;
            end else begin
              key_nxt = in_ext[KEY_WIDTH-1:0];
              cnt_nxt = cnt_r + CW'(1);
              pos_nxt = cnt_r + CW'(1);
            end
          end else begin
            if (heap_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              removed_nxt = root_r;
              cnt_nxt     = cnt_r - CW'(1);
            end
          end
        end
      end
      S_UP_CMP: begin
        if (cmp_gt) begin
          pos_nxt = pos_r >> 1;
        end
      end
      S_DN_LOAD: begin
        key_nxt = mem_rdata_a;
        pos_nxt = CW'(1);
      end
      S_DN_SEL: begin
        child_idx_nxt = CW'(sel_l + {{CW{1'b0}}, take_right});
        child_val_nxt = take_right ? mem_rdata_b : mem_rdata_a;
      end
      S_DN_CMP: begin
        if (cmp_gt) begin
          pos_nxt = child_idx_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // result register
  assign top_ext = {{VALUE_W{root_r[KEY_WIDTH-1]}}, root_r};
  assign rem_ext = {{VALUE_W{removed_r[KEY_WIDTH-1]}}, removed_r};
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_r};

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_top_nxt     = out_top_r;
    out_count_nxt   = out_count_r;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = status_r;
      out_removed_nxt = rem_ext[VALUE_W-1:0];
      out_top_nxt     = heap_empty ? '0 : top_ext[VALUE_W-1:0];
      out_count_nxt   = cnt_ext[COUNT_W-1:0];
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    key_r         <= key_nxt;
    child_val_r   <= child_val_nxt;
    child_idx_r   <= child_idx_nxt;
    root_r        <= root_nxt;
    removed_r     <= removed_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_top_r     <= out_top_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.top_value     = out_top_r;
  assign out_ch.count         = out_count_r;

endmodule

/* design/max_heap_priority_queue_top.sv */
// Top level of the binary max-heap priority queue.
//
//   channel  | direction | payload                                   | handshake
//   in_ch    | in        | action, value                             | valid/ready
//   out_ch   | out       | status, removed_value, top_value, count   | valid/ready
//
// An insert climbs one level per read/compare pair (S_UP_RD, S_UP_CMP);
// a delete-max fetches the last entry (S_DN_LAST, S_DN_LOAD), then
// descends one level per select/compare pair (S_DN_SEL, S_DN_CMP). The
// result register is loaded in S_DONE, and the next item is taken only
// back in S_IDLE; the pace is set by the single compare unit and the
// registered reads of the key store.
// Reset clears the entry count, the sequencer and the result valid; the
// key store is never cleared.
// A waiting result does not block the next command; a command that
// finishes while the result register is still full waits for it.
`timescale 1ns / 1ps

module max_heap_priority_queue_top #(
  parameter int CAPACITY  = hpq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = hpq_pkg::KEY_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  hpq_in_if.sink    in_ch,
  hpq_out_if.source out_ch
);
  import hpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr_a;
  logic [AW-1:0]        mem_raddr_b;
  logic [KEY_WIDTH-1:0] mem_rdata_a;
  logic [KEY_WIDTH-1:0] mem_rdata_b;
  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  logic                 cmp_gt;

  // sequencer
  hpq_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b),
    .cmp_a       (cmp_a),
    .cmp_b       (cmp_b),
    .cmp_gt      (cmp_gt)
  );

  // key store
  hpq_mem #(
    .DEPTH (CAPACITY),
    .DW    (KEY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // shared comparator
  hpq_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (cmp_gt)
  );

endmodule
